[design/csras_pkg.sv]
// Shared types and constants for the CSR access statistics classifier.
// Used by the front, queue, back and top-level modules; no dependencies.
package csras_pkg;

  // Width of each statistics counter; counters wrap at 2^COUNTER_WIDTH.
  localparam int COUNTER_WIDTH = 32;
  localparam int VALUE_WIDTH   = 32;
  localparam int NUM_COUNTERS  = 14;
  localparam int IDX_WIDTH     = $clog2(NUM_COUNTERS);

  // Upper 32 bits of the destination offset inside the CSR window.
  localparam logic [31:0] CSR_WINDOW_HI = 32'hFFFF_F000;

  localparam logic [15:0] OFS_STATE_CLEAR = 16'h0000;
  localparam logic [15:0] OFS_STATE_SET   = 16'h0004;
  localparam logic [15:0] OFS_BUS_MGR_ID  = 16'h021C;
  localparam logic [15:0] OFS_BANDWIDTH   = 16'h0220;
  localparam logic [15:0] OFS_CHANNELS_HI = 16'h0224;
  localparam logic [15:0] OFS_CHANNELS_LO = 16'h0228;
  localparam logic [15:0] OFS_BCAST_CHAN  = 16'h0234;
  localparam logic [15:0] OFS_FCP_CMD     = 16'h0B00;
  localparam logic [15:0] OFS_FCP_RSP     = 16'h0D00;

  localparam logic [3:0] TC_WRITE_QUAD  = 4'h0;
  localparam logic [3:0] TC_WRITE_BLOCK = 4'h1;
  localparam logic [3:0] TC_READ_QUAD   = 4'h4;
  localparam logic [3:0] TC_READ_BLOCK  = 4'h5;
  localparam logic [3:0] TC_LOCK        = 4'h9;

  typedef enum logic [4:0] {
    CAT_OUTSIDE     = 5'd0,
    CAT_ROM_READ    = 5'd1,
    CAT_STATE_CLEAR = 5'd2,
    CAT_STATE_SET   = 5'd3,
    CAT_BM_READ     = 5'd4,
    CAT_BM_LOCK     = 5'd5,
    CAT_BW_READ     = 5'd6,
    CAT_BW_LOCK     = 5'd7,
    CAT_CH_READ     = 5'd8,
    CAT_CH_LOCK     = 5'd9,
    CAT_BC_READ     = 5'd10,
    CAT_BC_WRITE    = 5'd11,
    CAT_TOPO_READ   = 5'd12,
    CAT_SPEED_READ  = 5'd13,
    CAT_FCP         = 5'd14,
    CAT_RESPONSE    = 5'd15,
    CAT_UNSUPPORTED = 5'd16
  } category_t;

  // Counter slot used for unsupported requests.
  localparam logic [IDX_WIDTH-1:0] IDX_UNSUPPORTED = IDX_WIDTH'(NUM_COUNTERS - 1);

  // One classified item as it travels from the front to the back.
  typedef struct packed {
    category_t             category;
    logic                  counted;
    logic [IDX_WIDTH-1:0]  idx;
  } class_item_t;

endpackage

[design/csras_front.sv]
// Front part: accepts received packets and classifies them by context,
// transaction code and CSR offset. Depends on csras_pkg.
module csras_front
  import csras_pkg::*;
(
  input  logic        pkt_valid,
  output logic        pkt_stall,
  input  logic        is_request,
  input  logic [3:0]  tcode,
  input  logic [47:0] dest_offset,
  output logic        push,
  output class_item_t push_item,
  input  logic        queue_full
);

  logic        rd;
  logic        rdq;
  logic        wr;
  logic        lk;
  logic [15:0] r;
  category_t   cat;

  assign pkt_stall = queue_full;
  assign push      = pkt_valid && !queue_full;

  always_comb begin
    rd  = (tcode == TC_READ_QUAD);
    rdq = (tcode == TC_READ_QUAD) || (tcode == TC_READ_BLOCK);
    wr  = (tcode == TC_WRITE_QUAD) || (tcode == TC_WRITE_BLOCK);
    lk  = (tcode == TC_LOCK);
    r   = dest_offset[15:0];

    if (!is_request) begin
      cat = CAT_RESPONSE;
    end else if (dest_offset[47:16] != CSR_WINDOW_HI) begin
      cat = CAT_OUTSIDE;
    end else if (r[15:10] == 6'b000001) begin
      // Config ROM takes priority over the single registers.
      cat = rdq ? CAT_ROM_READ : CAT_UNSUPPORTED;
    end else if (r == OFS_STATE_CLEAR) begin
      cat = wr ? CAT_STATE_CLEAR : CAT_UNSUPPORTED;
    end else if (r == OFS_STATE_SET) begin
      cat = wr ? CAT_STATE_SET : CAT_UNSUPPORTED;
    end else if (r == OFS_BUS_MGR_ID) begin
      cat = rd ? CAT_BM_READ : (lk ? CAT_BM_LOCK : CAT_UNSUPPORTED);
    end else if (r == OFS_BANDWIDTH) begin
      cat = rd ? CAT_BW_READ : (lk ? CAT_BW_LOCK : CAT_UNSUPPORTED);
    end else if (r == OFS_CHANNELS_HI || r == OFS_CHANNELS_LO) begin
      cat = rd ? CAT_CH_READ : (lk ? CAT_CH_LOCK : CAT_UNSUPPORTED);
    end else if (r == OFS_BCAST_CHAN) begin
      cat = rd ? CAT_BC_READ : (wr ? CAT_BC_WRITE : CAT_UNSUPPORTED);
    end else if (r[15:10] == 6'b000100) begin
      cat = rdq ? CAT_TOPO_READ : CAT_UNSUPPORTED;
    end else if (r[15:11] == 5'b00100) begin
      cat = rdq ? CAT_SPEED_READ : CAT_UNSUPPORTED;
    end else if (r == OFS_FCP_CMD || r == OFS_FCP_RSP) begin
      cat = CAT_FCP;
    end else begin
      cat = CAT_UNSUPPORTED;
    end

    push_item.category = cat;
    if (cat == CAT_UNSUPPORTED) begin
      push_item.counted = 1'b1;
      push_item.idx     = IDX_UNSUPPORTED;
    end else if (cat >= CAT_ROM_READ && cat <= CAT_SPEED_READ) begin
      push_item.counted = 1'b1;
      push_item.idx     = IDX_WIDTH'(cat - CAT_ROM_READ);
    end else begin
      push_item.counted = 1'b0;
      push_item.idx     = '0;
    end
  end

endmodule

[design/csras_queue.sv]
// Two-entry queue of classified items between the front and back parts.
// Depends on csras_pkg for the item type.
module csras_queue
  import csras_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  class_item_t push_item,
  output logic        full,
  input  logic        pop,
  output logic        not_empty,
  output class_item_t head,
  output logic [1:0]  level
);

  class_item_t slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = slots[rd_ptr];
  assign level     = count;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

[design/csras_back.sv]
// Back part: updates the statistics counters and holds the result register.
// Depends on csras_pkg.
module csras_back
  import csras_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        not_empty,
  input  class_item_t head,
  output logic        pop,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [4:0]  category,
  output logic        counted,
  output logic [31:0] count_value
);

  logic [COUNTER_WIDTH-1:0] counters [NUM_COUNTERS];
  logic [COUNTER_WIDTH-1:0] count_inc;

  assign pop       = not_empty && (!res_valid || !res_stall);
  assign count_inc = counters[head.idx] + COUNTER_WIDTH'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      for (int i = 0; i < NUM_COUNTERS; i++) begin
        counters[i] <= '0;
      end
    end else begin
      if (pop) begin
        res_valid <= 1'b1;
        if (head.counted) begin
          counters[head.idx] <= count_inc;
        end
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      category    <= head.category;
      counted     <= head.counted;
      count_value <= head.counted ? VALUE_WIDTH'(count_inc) : '0;
    end
  end

endmodule

[design/csr_access_stats_classifier.sv]
// Top level of the CSR access statistics classifier.
// Instantiates csras_front, csras_queue and csras_back; uses csras_pkg.
//
// The block takes one received asynchronous packet per item on the pkt
// channel and returns exactly one result item per packet on the res channel,
// in order. A request packet whose offset lies in 0xFFFFF0000000 through
// 0xFFFFF000FFFF is classified by offset and transaction code; the matching
// one of fourteen counters (thirteen access classes plus unsupported) is
// incremented, wrapping modulo 2^COUNTER_WIDTH, and its new value (low 32
// bits) is reported with the category. Responses, offsets outside the window
// and FCP addresses are reported but not counted, with a count value of zero.
// Throughput is one item per cycle while the output is not stalled: the front
// classifies in the accept cycle and writes a two-entry queue, and the back
// retires one queued item per cycle into the result register. The result
// register is loaded from the queue head when the back pops it, and a stall
// on a valid result holds the pop. The counters are cleared by reset
// directly; there is no clearing pass and no configuration port.
module csr_access_stats_classifier
  import csras_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        pkt_valid,
  output logic        pkt_stall,
  input  logic        is_request,
  input  logic [3:0]  tcode,
  input  logic [47:0] dest_offset,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [4:0]  category,
  output logic        counted,
  output logic [31:0] count_value
);

  logic        push;
  class_item_t push_item;
  logic        queue_full;
  logic        pop;
  logic        not_empty;
  class_item_t head;
  logic [1:0]  level;

  // Front: classification happens combinationally on the accepted item.
  csras_front u_front (
    .pkt_valid   (pkt_valid),
    .pkt_stall   (pkt_stall),
    .is_request  (is_request),
    .tcode       (tcode),
    .dest_offset (dest_offset),
    .push        (push),
    .push_item   (push_item),
    .queue_full  (queue_full)
  );

  // The queue decouples input stalls from output stalls.
  csras_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head),
    .level     (level)
  );

  // Back: counter update and the result register.
  csras_back u_back (
    .clk         (clk),
    .rst         (rst),
    .not_empty   (not_empty),
    .head        (head),
    .pop         (pop),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .category    (category),
    .counted     (counted),
    .count_value (count_value)
  );

  // The queue never holds more than its two entries.
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    level != 2'd3)
    else $error("queue level out of range");

  // A counted result always belongs to a counted class.
  a_counted_class: assert property (@(posedge clk) disable iff (rst)
    (res_valid && counted) |->
      ((category >= CAT_ROM_READ && category <= CAT_SPEED_READ) ||
       category == CAT_UNSUPPORTED))
    else $error("counted result with uncounted category");

  // An uncounted result reports a zero count value.
  a_uncounted_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !counted) |-> (count_value == 32'd0))
    else $error("uncounted result with nonzero value");

  // The back retires an item only when the queue has one.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> (level != 2'd0))
    else $error("pop from empty queue");

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for csr_access_stats_classifier: a directed table of
// packets, then random traffic, checked item by item against a local predictor.
// Depends on csras_pkg and the design files of the classifier.
module tb;
  import csras_pkg::*;

  // Run shape.
  localparam int RANDOM_ITEMS = 925;
  localparam int TAIL_ITEMS   = 150;   // last random items run with no idling
  localparam int HOLD_AT      = 300;   // random item that starts the long output hold-off
  localparam int HOLD_CYCLES  = 40;
  localparam int DRAIN_AT     = 600;   // random item before which the sender drains the block
  localparam int SETTLE       = 8;
  localparam int CYCLE_LIMIT  = 200000;

  // Transaction codes that the block treats as "anything else".
  localparam logic [3:0] TC_UNUSED_E = 4'hE;
  localparam logic [3:0] TC_UNUSED_F = 4'hF;

  // Ranges inside the CSR window, as offsets from its base.
  localparam logic [15:0] OFS_ROM_FIRST   = 16'h0400;
  localparam logic [15:0] OFS_ROM_LAST    = 16'h07FF;
  localparam logic [15:0] OFS_TOPO_FIRST  = 16'h1000;
  localparam logic [15:0] OFS_TOPO_LAST   = 16'h13FF;
  localparam logic [15:0] OFS_SPEED_FIRST = 16'h2000;
  localparam logic [15:0] OFS_SPEED_LAST  = 16'h27FF;
  localparam logic [15:0] OFS_WINDOW_LAST = 16'hFFFF;

  typedef struct packed {
    logic        is_request;
    logic [3:0]  tcode;
    logic [47:0] dest_offset;
  } packet_t;

  typedef struct packed {
    category_t   category;
    logic        counted;
    logic [31:0] count_value;
  } access_result_t;

  // One row of the directed table. When typed is set, want holds the result
  // written down by hand; otherwise the predictor supplies it.
  typedef struct {
    packet_t        pkt;
    logic           typed;
    access_result_t want;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 26;

  logic        clk;
  logic        rst;
  logic        pkt_valid;
  logic        pkt_stall;
  logic        is_request;
  logic [3:0]  tcode;
  logic [47:0] dest_offset;
  logic        res_valid;
  logic        res_stall;
  logic [4:0]  category;
  logic        counted;
  logic [31:0] count_value;

  // Predictor state: one tally per counted class, the last slot for
  // unsupported requests, mirroring the block's counter bank.
  logic [COUNTER_WIDTH-1:0] access_tally [NUM_COUNTERS];
  access_result_t           pending_results [$];
  access_result_t           arrived_want;

  int   mismatch_count = 0;
  int   cycle_count    = 0;
  logic tail_phase     = 1'b0;
  logic hold_req       = 1'b0;
  logic hold_done      = 1'b0;

  csr_access_stats_classifier DUT (
    .clk         (clk),
    .rst         (rst),
    .pkt_valid   (pkt_valid),
    .pkt_stall   (pkt_stall),
    .is_request  (is_request),
    .tcode       (tcode),
    .dest_offset (dest_offset),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .category    (category),
    .counted     (counted),
    .count_value (count_value)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  initial begin
    rst = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
  end

  // The watchdog. A correct run ends far below this limit even with every
  // idle burst at its longest on both sides.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Calm stretches: neither side idles here, so back-to-back traffic at the
  // full rate is seen regularly, and always in the tail of the run.
  function automatic logic calm_window();
    return tail_phase || ((cycle_count / 200) % 4 == 3);
  endfunction

  // Classification of a request inside the CSR window. The config ROM range
  // is tested ahead of the single registers, as in the block.
  function automatic category_t classify_access(logic [3:0] tc, logic [15:0] ofs);
    logic rd;
    logic rdq;
    logic wr;
    logic lk;
    rd  = (tc == TC_READ_QUAD);
    rdq = rd || (tc == TC_READ_BLOCK);
    wr  = (tc == TC_WRITE_QUAD) || (tc == TC_WRITE_BLOCK);
    lk  = (tc == TC_LOCK);
    if (ofs >= OFS_ROM_FIRST && ofs <= OFS_ROM_LAST)
      return rdq ? CAT_ROM_READ : CAT_UNSUPPORTED;
    if (ofs == OFS_STATE_CLEAR)
      return wr ? CAT_STATE_CLEAR : CAT_UNSUPPORTED;
    if (ofs == OFS_STATE_SET)
      return wr ? CAT_STATE_SET : CAT_UNSUPPORTED;
    if (ofs == OFS_BUS_MGR_ID)
      return rd ? CAT_BM_READ : (lk ? CAT_BM_LOCK : CAT_UNSUPPORTED);
    if (ofs == OFS_BANDWIDTH)
      return rd ? CAT_BW_READ : (lk ? CAT_BW_LOCK : CAT_UNSUPPORTED);
    if (ofs == OFS_CHANNELS_HI || ofs == OFS_CHANNELS_LO)
      return rd ? CAT_CH_READ : (lk ? CAT_CH_LOCK : CAT_UNSUPPORTED);
    if (ofs == OFS_BCAST_CHAN)
      return rd ? CAT_BC_READ : (wr ? CAT_BC_WRITE : CAT_UNSUPPORTED);
    if (ofs >= OFS_TOPO_FIRST && ofs <= OFS_TOPO_LAST)
      return rdq ? CAT_TOPO_READ : CAT_UNSUPPORTED;
    if (ofs >= OFS_SPEED_FIRST && ofs <= OFS_SPEED_LAST)
      return rdq ? CAT_SPEED_READ : CAT_UNSUPPORTED;
    if (ofs == OFS_FCP_CMD || ofs == OFS_FCP_RSP)
      return CAT_FCP;
    return CAT_UNSUPPORTED;
  endfunction

  // Works out the result of one accepted packet and advances the tallies.
  function automatic access_result_t predict_access(packet_t p);
    access_result_t r;
    int             slot;
    r.category    = CAT_RESPONSE;
    r.counted     = 1'b0;
    r.count_value = '0;
    if (p.is_request) begin
      if (p.dest_offset[47:16] != CSR_WINDOW_HI) begin
        r.category = CAT_OUTSIDE;
      end else begin
        r.category = classify_access(p.tcode, p.dest_offset[15:0]);
        // FCP is accepted but leaves every tally alone.
        if (r.category != CAT_FCP) begin
          slot = (r.category == CAT_UNSUPPORTED) ? NUM_COUNTERS - 1 : int'(r.category) - 1;
          access_tally[slot] = access_tally[slot] + 1'b1;
          r.counted          = 1'b1;
          r.count_value      = 32'(access_tally[slot]);
        end
      end
    end
    return r;
  endfunction

  function automatic stim_row_t stim_row(logic req, logic [3:0] tc, logic [47:0] ofs,
                                         logic typed, category_t cat, logic cnt,
                                         logic [31:0] val);
    stim_row_t s;
    s.pkt.is_request       = req;
    s.pkt.tcode            = tc;
    s.pkt.dest_offset      = ofs;
    s.typed                = typed;
    s.want.category        = cat;
    s.want.counted         = cnt;
    s.want.count_value     = val;
    return s;
  endfunction

  // The directed table. Every count is the first, second or third hit of its
  // tally after reset, so the typed results follow directly.
  function automatic stim_row_t directed_row(int n);
    case (n)
      // Response context wins over any tcode and any address.
      0:  return stim_row(1'b0, TC_UNUSED_F, 48'hFFFF_FFFF_FFFF, 1'b1, CAT_RESPONSE, 1'b0, 0);
      1:  return stim_row(1'b0, TC_READ_QUAD, {CSR_WINDOW_HI, OFS_ROM_FIRST},
                          1'b1, CAT_RESPONSE, 1'b0, 0);
      // Requests just outside the window on both sides, and the extremes.
      2:  return stim_row(1'b1, TC_WRITE_QUAD, 48'h0, 1'b1, CAT_OUTSIDE, 1'b0, 0);
      3:  return stim_row(1'b1, TC_READ_QUAD, 48'hFFFF_EFFF_FFFF, 1'b1, CAT_OUTSIDE, 1'b0, 0);
      4:  return stim_row(1'b1, TC_WRITE_QUAD, 48'hFFFF_F001_0000, 1'b1, CAT_OUTSIDE, 1'b0, 0);
      5:  return stim_row(1'b1, TC_UNUSED_F, 48'hFFFF_FFFF_FFFF, 1'b1, CAT_OUTSIDE, 1'b0, 0);
      // Every counted class.
      6:  return stim_row(1'b1, TC_WRITE_QUAD, {CSR_WINDOW_HI, OFS_STATE_CLEAR},
                          1'b1, CAT_STATE_CLEAR, 1'b1, 1);
      7:  return stim_row(1'b1, TC_WRITE_BLOCK, {CSR_WINDOW_HI, OFS_STATE_SET},
                          1'b1, CAT_STATE_SET, 1'b1, 1);
      8:  return stim_row(1'b1, TC_READ_QUAD, {CSR_WINDOW_HI, OFS_ROM_FIRST},
                          1'b1, CAT_ROM_READ, 1'b1, 1);
      9:  return stim_row(1'b1, TC_READ_BLOCK, {CSR_WINDOW_HI, OFS_ROM_LAST},
                          1'b1, CAT_ROM_READ, 1'b1, 2);
      // A write into the config ROM is unsupported.
      10: return stim_row(1'b1, TC_WRITE_QUAD, {CSR_WINDOW_HI, OFS_ROM_FIRST},
                          1'b1, CAT_UNSUPPORTED, 1'b1, 1);
      11: return stim_row(1'b1, TC_READ_QUAD, {CSR_WINDOW_HI, OFS_BUS_MGR_ID},
                          1'b1, CAT_BM_READ, 1'b1, 1);
      12: return stim_row(1'b1, TC_LOCK, {CSR_WINDOW_HI, OFS_BUS_MGR_ID},
                          1'b1, CAT_BM_LOCK, 1'b1, 1);
      // A listed register with the wrong tcode.
      13: return stim_row(1'b1, TC_READ_BLOCK, {CSR_WINDOW_HI, OFS_BUS_MGR_ID},
                          1'b1, CAT_UNSUPPORTED, 1'b1, 2);
      14: return stim_row(1'b1, TC_READ_QUAD, {CSR_WINDOW_HI, OFS_BANDWIDTH},
                          1'b1, CAT_BW_READ, 1'b1, 1);
      15: return stim_row(1'b1, TC_LOCK, {CSR_WINDOW_HI, OFS_BANDWIDTH},
                          1'b1, CAT_BW_LOCK, 1'b1, 1);
      16: return stim_row(1'b1, TC_READ_QUAD, {CSR_WINDOW_HI, OFS_CHANNELS_HI},
                          1'b1, CAT_CH_READ, 1'b1, 1);
      17: return stim_row(1'b1, TC_LOCK, {CSR_WINDOW_HI, OFS_CHANNELS_LO},
                          1'b1, CAT_CH_LOCK, 1'b1, 1);
      18: return stim_row(1'b1, TC_READ_QUAD, {CSR_WINDOW_HI, OFS_BCAST_CHAN},
                          1'b1, CAT_BC_READ, 1'b1, 1);
      19: return stim_row(1'b1, TC_WRITE_BLOCK, {CSR_WINDOW_HI, OFS_BCAST_CHAN},
                          1'b1, CAT_BC_WRITE, 1'b1, 1);
      20: return stim_row(1'b1, TC_READ_BLOCK, {CSR_WINDOW_HI, OFS_TOPO_FIRST},
                          1'b1, CAT_TOPO_READ, 1'b1, 1);
      21: return stim_row(1'b1, TC_READ_QUAD, {CSR_WINDOW_HI, OFS_SPEED_LAST},
                          1'b1, CAT_SPEED_READ, 1'b1, 1);
      // FCP takes any tcode and is never counted.
      22: return stim_row(1'b1, TC_UNUSED_F, {CSR_WINDOW_HI, OFS_FCP_CMD},
                          1'b1, CAT_FCP, 1'b0, 0);
      23: return stim_row(1'b1, TC_WRITE_QUAD, {CSR_WINDOW_HI, OFS_FCP_RSP},
                          1'b1, CAT_FCP, 1'b0, 0);
      24: return stim_row(1'b1, TC_UNUSED_F, {CSR_WINDOW_HI, OFS_WINDOW_LAST},
                          1'b1, CAT_UNSUPPORTED, 1'b1, 3);
      // Range edges, left to the predictor.
      25: return stim_row(1'b1, TC_READ_QUAD, {CSR_WINDOW_HI, OFS_SPEED_LAST + 16'd1},
                          1'b0, CAT_OUTSIDE, 1'b0, 0);
      default: return stim_row(1'b1, TC_READ_QUAD, {CSR_WINDOW_HI, OFS_TOPO_LAST},
                               1'b0, CAT_OUTSIDE, 1'b0, 0);
    endcase
  endfunction

  function automatic logic [15:0] pick_register();
    case ($urandom_range(0, 8))
      0:       return OFS_STATE_CLEAR;
      1:       return OFS_STATE_SET;
      2:       return OFS_BUS_MGR_ID;
      3:       return OFS_BANDWIDTH;
      4:       return OFS_CHANNELS_HI;
      5:       return OFS_CHANNELS_LO;
      6:       return OFS_BCAST_CHAN;
      7:       return OFS_FCP_CMD;
      default: return OFS_FCP_RSP;
    endcase
  endfunction

  // Mostly the codes the block decodes, the rest anything at all.
  function automatic logic [3:0] pick_tcode();
    if ($urandom_range(0, 9) < 3)
      return 4'($urandom);
    case ($urandom_range(0, 4))
      0:       return TC_WRITE_QUAD;
      1:       return TC_WRITE_BLOCK;
      2:       return TC_READ_QUAD;
      3:       return TC_READ_BLOCK;
      default: return TC_LOCK;
    endcase
  endfunction

  // Random packets: most are requests aimed at the decoded registers and
  // ranges; some land near their edges, near the window edges, or anywhere.
  function automatic packet_t random_packet();
    packet_t     p;
    logic [31:0] hi;
    p.is_request  = ($urandom_range(0, 9) != 0);
    p.tcode       = pick_tcode();
    p.dest_offset = {CSR_WINDOW_HI, 16'h0};
    case ($urandom_range(0, 15))
      0, 1: p.dest_offset = {16'($urandom), 32'($urandom)};
      2: begin
        hi = CSR_WINDOW_HI + ($urandom_range(0, 1) ? 32'd1 : 32'hFFFF_FFFF);
        p.dest_offset = {hi, 16'($urandom)};
      end
      3:    p.dest_offset[15:0] = 16'($urandom);
      4, 5: p.dest_offset[15:0] = OFS_ROM_FIRST + 16'($urandom_range(0, 16'h03FF));
      10:   p.dest_offset[15:0] = OFS_TOPO_FIRST + 16'($urandom_range(0, 16'h03FF));
      11:   p.dest_offset[15:0] = OFS_SPEED_FIRST + 16'($urandom_range(0, 16'h07FF));
      12: begin
        // Near the range edges.
        case ($urandom_range(0, 2))
          0:       p.dest_offset[15:0] = OFS_ROM_FIRST;
          1:       p.dest_offset[15:0] = OFS_TOPO_FIRST;
          default: p.dest_offset[15:0] = OFS_SPEED_FIRST;
        endcase
        if ($urandom_range(0, 1))
          p.dest_offset[15:0] = p.dest_offset[15:0] - 16'd1;
      end
      13:   p.dest_offset[15:0] = pick_register() + 16'($urandom_range(0, 6)) - 16'd3;
      default: p.dest_offset[15:0] = pick_register();
    endcase
    return p;
  endfunction

  function automatic int pick_gap();
    if (calm_window() || (hold_req && !hold_done) || $urandom_range(0, 3) != 0)
      return 0;
    return $urandom_range(1, 5);
  endfunction

  // Offers one packet and returns at the edge where it is accepted, with the
  // expected result queued. A positive gap first drops valid and idles for the gap.
  task automatic offer_packet(packet_t p, int gap, logic typed, access_result_t typed_want);
    access_result_t predicted;
    if (gap > 0) begin
      pkt_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    is_request  <= p.is_request;
    tcode       <= p.tcode;
    dest_offset <= p.dest_offset;
    pkt_valid   <= 1'b1;
    @(posedge clk);
    while (pkt_stall) @(posedge clk);
    // The predictor always runs so that its tallies track the block.
    predicted = predict_access(p);
    pending_results.push_back(typed ? typed_want : predicted);
  endtask

  // Sender: the directed table, then random traffic, then the end of run.
  initial begin : packet_source
    stim_row_t row;
    pkt_valid   = 1'b0;
    is_request  = 1'b0;
    tcode       = '0;
    dest_offset = '0;
    for (int i = 0; i < NUM_COUNTERS; i++)
      access_tally[i] = '0;
    @(negedge rst);
    @(posedge clk);

    for (int n = 0; n < DIRECTED_ROWS; n++) begin
      row = directed_row(n);
      offer_packet(row.pkt, pick_gap(), row.typed, row.want);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - TAIL_ITEMS)
        tail_phase = 1'b1;
      // Start the long hold-off on the result side; gaps stay off until it
      // ends, so the queue fills and the input stalls.
      if (n == HOLD_AT)
        hold_req = 1'b1;
      // Stop offering until every outstanding result has come back.
      if (n == DRAIN_AT) begin
        pkt_valid <= 1'b0;
        wait (pending_results.size() == 0);
        @(posedge clk);
      end
      offer_packet(random_packet(), pick_gap(), 1'b0, '0);
    end

    pkt_valid <= 1'b0;
    wait (pending_results.size() == 0);
    // The settle wait catches any stray result after the last one.
    repeat (SETTLE) @(posedge clk);
    if (mismatch_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  // Receiver: random stall bursts outside calm stretches,
  // plus one long hold-off requested by the sender.
  initial begin : result_sink
    res_stall = 1'b0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        res_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (!calm_window() && $urandom_range(0, 3) == 0) begin
        res_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        res_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  // Each accepted result is checked field by field against the oldest
  // outstanding expectation.
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing outstanding: category %0d counted %0d count_value %0d",
               category, counted, count_value);
        mismatch_count++;
      end else begin
        arrived_want = pending_results.pop_front();
        if (category !== arrived_want.category) begin
          $error("category: expected %0d, actual %0d", arrived_want.category, category);
          mismatch_count++;
        end
        if (counted !== arrived_want.counted) begin
          $error("counted: expected %0d, actual %0d", arrived_want.counted, counted);
          mismatch_count++;
        end
        if (count_value !== arrived_want.count_value) begin
          $error("count_value: expected %0d, actual %0d", arrived_want.count_value,
                 count_value);
          mismatch_count++;
        end
      end
    end
  end

endmodule
